// ===== rtl/core/ss1kd_pkg.sv =====
package ss1kd_pkg;

  // prefix state codes
  typedef enum logic [1:0] {
    ST_BASE  = 2'd0,
    ST_E0    = 2'd1,
    ST_E1    = 2'd2,
    ST_E1_1D = 2'd3
  } prefix_state_t;

  // lookup outcome codes
  typedef enum logic [1:0] {
    LK_INVALID = 2'd0,
    LK_KEY     = 2'd1,
    LK_HOLE    = 2'd2,
    LK_PREFIX  = 2'd3
  } lkind_t;

  typedef struct packed {
    lkind_t        kind;
    logic [7:0]    key;
    prefix_state_t nxt;
  } lookup_t;

  // scan bytes with special meaning
  localparam logic [7:0] SC_E0       = 8'he0;
  localparam logic [7:0] SC_E1       = 8'he1;
  localparam logic [7:0] SC_F1       = 8'hf1;
  localparam logic [7:0] SC_F2       = 8'hf2;
  localparam logic [7:0] SC_FF       = 8'hff;
  localparam logic [7:0] SC_AA       = 8'haa;
  localparam logic [7:0] SC_2A       = 8'h2a;
  localparam logic [7:0] SC_36       = 8'h36;
  localparam logic [7:0] SC_1D       = 8'h1d;
  localparam logic [7:0] SC_PAUSE    = 8'h45;
  localparam logic [7:0] SC_EXT_END  = 8'h5e;

  // key positions not taken from the tables
  localparam logic [7:0] KEY_PAUSE   = 8'd126;
  localparam logic [7:0] KEY_F1      = 8'd150;
  localparam logic [7:0] KEY_F2      = 8'd151;
  localparam logic [7:0] KEY_NONE    = 8'd0;

  // base key positions for bytes 00..7f
  function automatic logic [7:0] base_key_f(input logic [6:0] a);
    logic [7:0] k;
    unique case (a)
      7'h01: k = 8'd110; 7'h02: k = 8'd2;   7'h03: k = 8'd3;   7'h04: k = 8'd4;
      7'h05: k = 8'd5;   7'h06: k = 8'd6;   7'h07: k = 8'd7;   7'h08: k = 8'd8;
      7'h09: k = 8'd9;   7'h0a: k = 8'd10;  7'h0b: k = 8'd11;  7'h0c: k = 8'd12;
      7'h0d: k = 8'd13;  7'h0e: k = 8'd15;  7'h0f: k = 8'd16;  7'h10: k = 8'd17;
      7'h11: k = 8'd18;  7'h12: k = 8'd19;  7'h13: k = 8'd20;  7'h14: k = 8'd21;
      7'h15: k = 8'd22;  7'h16: k = 8'd23;  7'h17: k = 8'd24;  7'h18: k = 8'd25;
      7'h19: k = 8'd26;  7'h1a: k = 8'd27;  7'h1b: k = 8'd28;  7'h1c: k = 8'd43;
      7'h1d: k = 8'd58;  7'h1e: k = 8'd31;  7'h1f: k = 8'd32;  7'h20: k = 8'd33;
      7'h21: k = 8'd34;  7'h22: k = 8'd35;  7'h23: k = 8'd36;  7'h24: k = 8'd37;
      7'h25: k = 8'd38;  7'h26: k = 8'd39;  7'h27: k = 8'd40;  7'h28: k = 8'd41;
      7'h29: k = 8'd1;   7'h2a: k = 8'd44;  7'h2b: k = 8'd29;  7'h2c: k = 8'd46;
      7'h2d: k = 8'd47;  7'h2e: k = 8'd48;  7'h2f: k = 8'd49;  7'h30: k = 8'd50;
      7'h31: k = 8'd51;  7'h32: k = 8'd52;  7'h33: k = 8'd53;  7'h34: k = 8'd54;
      7'h35: k = 8'd55;  7'h36: k = 8'd57;  7'h37: k = 8'd100; 7'h38: k = 8'd60;
      7'h39: k = 8'd61;  7'h3a: k = 8'd30;  7'h3b: k = 8'd112; 7'h3c: k = 8'd113;
      7'h3d: k = 8'd114; 7'h3e: k = 8'd115; 7'h3f: k = 8'd116; 7'h40: k = 8'd117;
      7'h41: k = 8'd118; 7'h42: k = 8'd119; 7'h43: k = 8'd120; 7'h44: k = 8'd121;
      7'h45: k = 8'd90;  7'h46: k = 8'd125; 7'h47: k = 8'd91;  7'h48: k = 8'd96;
      7'h49: k = 8'd101; 7'h4a: k = 8'd105; 7'h4b: k = 8'd92;  7'h4c: k = 8'd97;
      7'h4d: k = 8'd102; 7'h4e: k = 8'd106; 7'h4f: k = 8'd93;  7'h50: k = 8'd98;
      7'h51: k = 8'd103; 7'h52: k = 8'd99;  7'h53: k = 8'd104; 7'h54: k = 8'd124;
      7'h56: k = 8'd45;  7'h57: k = 8'd122; 7'h58: k = 8'd123; 7'h70: k = 8'd133;
      7'h73: k = 8'd56;  7'h79: k = 8'd132; 7'h7b: k = 8'd131; 7'h7d: k = 8'd14;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  // key positions after e0, zero beyond 5d
  function automatic logic [7:0] ext_key_f(input logic [6:0] a);
    logic [7:0] k;
    unique case (a)
      7'h1c: k = 8'd108; 7'h1d: k = 8'd64;  7'h35: k = 8'd95;  7'h37: k = 8'd124;
      7'h38: k = 8'd62;  7'h46: k = 8'd126; 7'h47: k = 8'd80;  7'h48: k = 8'd83;
      7'h49: k = 8'd85;  7'h4b: k = 8'd79;  7'h4d: k = 8'd89;  7'h4f: k = 8'd81;
      7'h50: k = 8'd84;  7'h51: k = 8'd86;  7'h52: k = 8'd75;  7'h53: k = 8'd76;
      7'h5b: k = 8'd59;  7'h5c: k = 8'd63;  7'h5d: k = 8'd65;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  // classify one byte in one prefix state, given the rom words for b[6:0]
  function automatic lookup_t lookup_f(input prefix_state_t st, input logic [7:0] b,
                                       input logic [7:0] bkey, input logic [7:0] xkey);
    lookup_t r;
    r.kind = LK_INVALID;
    r.key  = KEY_NONE;
    r.nxt  = ST_BASE;
    unique case (st)
      ST_BASE: begin
        if (!b[7]) begin
          if (bkey != KEY_NONE) begin
            r.kind = LK_KEY;
            r.key  = bkey;
          end
        end else if (b == SC_E0) begin
          r.kind = LK_PREFIX;
          r.nxt  = ST_E0;
        end else if (b == SC_E1) begin
          r.kind = LK_PREFIX;
          r.nxt  = ST_E1;
        end else if (b == SC_F1) begin
          r.kind = LK_KEY;
          r.key  = KEY_F1;
        end else if (b == SC_F2) begin
          r.kind = LK_KEY;
          r.key  = KEY_F2;
        end else if (b == SC_FF) begin
          r.kind = LK_HOLE;
        end
      end
      ST_E0: begin
        if (b == SC_AA || b == SC_2A || b == SC_36) begin
          r.kind = LK_HOLE;
        end else if (b < SC_EXT_END && xkey != KEY_NONE) begin
          r.kind = LK_KEY;
          r.key  = xkey;
        end
      end
      ST_E1: begin
        if (b == SC_1D) begin
          r.kind = LK_PREFIX;
          r.nxt  = ST_E1_1D;
        end
      end
      ST_E1_1D: begin
        if (b == SC_PAUSE) begin
          r.kind = LK_KEY;
          r.key  = KEY_PAUSE;
        end
      end
      default: r.kind = LK_INVALID;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/scan_set1_key_decoder.sv =====
// path: an accepted word is registered in the rom read stage, then decoded into the
// output register; throughput: one word per cycle unless out_stall holds a waiting
// output word; the read stage and the output register each hold one word, and the prefix state updates in decode
// reset: synchronous, active low; empties both stages and sets the prefix
// state to base
module scan_set1_key_decoder
  import ss1kd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_key_position,
  output logic       out_released
);

  // read stage registers
  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_code_r;
  logic [7:0]    s1_bkey_r;
  logic [7:0]    s1_xkey_r;

  // prefix state and output register
  prefix_state_t state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_key_r;
  logic          out_rel_r;

  logic          in_acc;
  logic          out_ready;
  logic          s1_go;
  logic          emit;
  logic          use_retry;
  lookup_t       first_lk, retry_lk, sel_lk;

  // handshake
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!emit || out_ready);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_acc    = in_valid && !in_stall;

  // rom read stage: both tables at the low seven bits serve lookup and retry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_code_r <= in_scan_code;
      s1_bkey_r <= base_key_f(in_scan_code[6:0]);
      s1_xkey_r <= ext_key_f(in_scan_code[6:0]);
    end
  end

  // decode: lookup, then retry as a break with bit 7 cleared
  always_comb begin
    first_lk  = lookup_f(state_r, s1_code_r, s1_bkey_r, s1_xkey_r);
    retry_lk  = lookup_f(state_r, {1'b0, s1_code_r[6:0]}, s1_bkey_r, s1_xkey_r);
    use_retry = (first_lk.kind == LK_INVALID) && s1_code_r[7] &&
                (retry_lk.kind != LK_INVALID);
    sel_lk    = use_retry ? retry_lk : first_lk;
    emit      = (sel_lk.kind == LK_KEY);
  end

  // next prefix state
  always_comb begin
    state_nxt = state_r;
    if (s1_go) begin
      state_nxt = (sel_lk.kind == LK_PREFIX) ? sel_lk.nxt : ST_BASE;
    end
  end

  // stage valids
  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_go);
    out_valid_nxt = out_ready ? (s1_go && emit) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BASE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_key_r <= sel_lk.key;
      out_rel_r <= use_retry;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_position = out_key_r;
  assign out_released     = out_rel_r;

  // pause prefix is only reached from the e1 state
  a_e1_1d_from_e1: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_E1_1D && $past(state_r) != ST_E1_1D) |-> $past(state_r) == ST_E1)
    else $error("e1 1d state entered from wrong state");

  // input is held back only by a waiting word in the read stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without cause");

  // f1 and f2 keys only come as presses
  a_no_f1_f2_break: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rel_r) |-> (out_key_r != KEY_F1 && out_key_r != KEY_F2))
    else $error("release of f1 or f2 key");

endmodule
